@@ sv/gtb_pkg.sv @@
// Shared types and constants of the Goertzel tone bank.
package gtb_pkg;

    localparam int BANK    = 7;
    localparam int DELAY_W = 40;
    localparam int MAG_W   = 24;
    localparam int COEF_W  = 16;
    localparam int BIN_W   = 7;
    localparam int IDX_W   = 3;
    localparam int ADDR_W  = 5;
    localparam int SQ_W    = 49;
    localparam int ROOT_W  = 25;
    localparam int SQ_STEPS = 25;
    localparam int TAB_LEN = 128;

    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [IDX_W-1:0] REG_BIN_INDEX_0 = 3'd0;
    localparam logic [IDX_W-1:0] REG_BIN_INDEX_6 = 3'd6;

    localparam logic [BIN_W-1:0] BIN_RESET [BANK] =
        '{7'd11, 7'd12, 7'd14, 7'd15, 7'd19, 7'd21, 7'd24};

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_stat_t;

endpackage

@@ sv/gtb_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module gtb_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [gtb_pkg::SQ_W-1:0]   value,
    output gtb_pkg::sqrt_stat_t        stat
);

    logic [gtb_pkg::SQ_W-1:0] v_reg;
    logic [gtb_pkg::SQ_W:0]   res_reg;
    logic [4:0]               cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic [gtb_pkg::SQ_W:0]   bit_next;
    logic [gtb_pkg::SQ_W:0]   trial_next;
    logic                     take_next;

    assign bit_next   = (gtb_pkg::SQ_W+1)'(1) << {cnt_reg, 1'b0};
    assign trial_next = res_reg + bit_next;
    assign take_next  = {1'b0, v_reg} >= trial_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            v_reg    <= '0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                v_reg    <= value;
                res_reg  <= '0;
                cnt_reg  <= 5'(gtb_pkg::SQ_STEPS - 1);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (take_next)
                begin
                    v_reg   <= v_reg - trial_next[gtb_pkg::SQ_W-1:0];
                    res_reg <= (res_reg >> 1) + bit_next;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 5'd1;
                end
            end
        end
    end

    assign stat.done = done_reg;
    assign stat.root = res_reg[gtb_pkg::ROOT_W-1:0];

endmodule

@@ sv/goertzel_tone_bank_core.sv @@
// Top level of the Goertzel tone bank: sequencer, shared multiplier, registers.
// On the sample closing a block each unsaturated bin also runs the 25-step root.
// A new sample is taken only in idle, once the last one has finished; one 40x25 multiplier.
// Reset clears delays, sample counter and magnitudes, and loads default bin indices.
// The output register lets the next sample enter while a beat waits.
module goertzel_tone_bank_core #(
    parameter int BLOCK_LEN   = 256,
    parameter int NUM_BINS    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [gtb_pkg::ADDR_W-1:0]            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin0,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin1,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin2,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin3,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin4,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin5,
    output logic [gtb_pkg::MAG_W-1:0]             mag_bin6,
    output logic                                  block_done
);

    localparam int CNT_W = $clog2(BLOCK_LEN);
    localparam logic [gtb_pkg::IDX_W-1:0] LAST_BIN = gtb_pkg::IDX_W'(NUM_BINS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_COEF, ST_FB_MUL, ST_FB_ADD, ST_RE_MUL, ST_RE_SUB,
        ST_IM, ST_SQ_RE, ST_SQ_IM, ST_SQ_SUM, ST_ROOT, ST_FINISH
    } state_t;

    function automatic logic signed [16:0] round_q15(input logic signed [63:0] sum);
        logic [63:0] m;
        if (sum < 0)
            m = '0;
        else
            m = (64'(sum) + 64'd16384) >> 15;
        if (m > 64'd32767)
            m = 64'd32767;
        return 17'(m);
    endfunction

    function automatic logic [31:0] trig_entry(input int unsigned k);
        logic [63:0] phase;
        logic [63:0] r;
        logic [63:0] theta;
        logic [63:0] t2;
        logic [63:0] ts;
        logic [63:0] tc;
        logic signed [63:0] ss;
        logic signed [63:0] cs;
        logic [1:0] q;
        logic signed [16:0] c;
        logic signed [16:0] s;
        logic signed [16:0] co;
        logic signed [16:0] si;
        phase = (64'(k % BLOCK_LEN) << 32) / 64'(BLOCK_LEN);
        q     = phase[31:30];
        r     = {34'd0, phase[29:0]};
        theta = (r * 64'd1686629713) >> 30;
        t2    = (theta * theta) >> 30;
        ts = theta;
        tc = 64'd1 << 30;
        ss = $signed(ts);
        cs = $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd6;   tc = ((tc * t2) >> 30) / 64'd2;
        ss = ss - $signed(ts);            cs = cs - $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd20;  tc = ((tc * t2) >> 30) / 64'd12;
        ss = ss + $signed(ts);            cs = cs + $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd42;  tc = ((tc * t2) >> 30) / 64'd30;
        ss = ss - $signed(ts);            cs = cs - $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd72;  tc = ((tc * t2) >> 30) / 64'd56;
        ss = ss + $signed(ts);            cs = cs + $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd110; tc = ((tc * t2) >> 30) / 64'd90;
        ss = ss - $signed(ts);            cs = cs - $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd156; tc = ((tc * t2) >> 30) / 64'd132;
        ss = ss + $signed(ts);            cs = cs + $signed(tc);
        ts = ((ts * t2) >> 30) / 64'd210; tc = ((tc * t2) >> 30) / 64'd182;
        ss = ss - $signed(ts);            cs = cs - $signed(tc);
        c = round_q15(cs);
        s = round_q15(ss);
        case (q)
            2'd0:
            begin
                co = c;
                si = s;
            end
            2'd1:
            begin
                co = -s;
                si = c;
            end
            2'd2:
            begin
                co = -c;
                si = -s;
            end
            default:
            begin
                co = s;
                si = -c;
            end
        endcase
        return {co[15:0], si[15:0]};
    endfunction

    function automatic logic [gtb_pkg::TAB_LEN*32-1:0] build_tab();
        logic [gtb_pkg::TAB_LEN*32-1:0] tab;
        tab = '0;
        for (int k = 0; k < gtb_pkg::TAB_LEN; k++)
            tab[k*32 +: 32] = trig_entry(k);
        return tab;
    endfunction

    localparam logic [gtb_pkg::TAB_LEN*32-1:0] TRIG_TAB = build_tab();

    state_t                                  state_reg;
    logic [gtb_pkg::IDX_W-1:0]               bin_reg;
    logic [CNT_W-1:0]                        count_reg;
    logic                                    blk_done_reg;
    logic                                    blk_flag_reg;
    logic signed [gtb_pkg::DELAY_W-1:0]      x_reg;
    logic signed [gtb_pkg::COEF_W-1:0]       cos_reg;
    logic signed [gtb_pkg::COEF_W-1:0]       sin_reg;
    logic signed [64:0]                      prod_reg;
    logic signed [gtb_pkg::DELAY_W-1:0]      s0_reg;
    logic signed [gtb_pkg::DELAY_W:0]        re_reg;
    logic signed [gtb_pkg::DELAY_W-1:0]      im_reg;
    logic                                    sat_reg;
    logic [47:0]                             acc_reg;
    logic signed [gtb_pkg::DELAY_W-1:0]      d1_reg [gtb_pkg::BANK];
    logic signed [gtb_pkg::DELAY_W-1:0]      d2_reg [gtb_pkg::BANK];
    logic [gtb_pkg::MAG_W-1:0]               held_reg [gtb_pkg::BANK];
    logic [gtb_pkg::MAG_W-1:0]               mag_out_reg [gtb_pkg::BANK];
    logic                                    out_valid_reg;
    logic [gtb_pkg::BIN_W-1:0]               bin_index_reg [gtb_pkg::BANK];

    logic signed [gtb_pkg::DELAY_W-1:0]      mul_a;
    logic signed [24:0]                      mul_b;
    logic signed [64:0]                      mul_p;
    logic [31:0]                             trig_word;
    logic signed [gtb_pkg::DELAY_W-1:0]      s0_next;
    logic signed [gtb_pkg::DELAY_W:0]        re_next;
    logic signed [gtb_pkg::DELAY_W-1:0]      im_next;
    logic [gtb_pkg::DELAY_W:0]               ar_next;
    logic [gtb_pkg::DELAY_W-1:0]             ai_next;
    logic [gtb_pkg::SQ_W-1:0]                sq_sum_next;
    logic                                    sq_start;
    logic                                    last_bin;
    logic                                    out_free;
    logic                                    cfg_wr;
    logic [gtb_pkg::IDX_W-1:0]               cfg_idx;
    gtb_pkg::sqrt_stat_t                     sq_stat;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[gtb_pkg::ADDR_W-1:2];
    assign cfg_wr   = psel && penable && pwrite && (cfg_idx <= gtb_pkg::REG_BIN_INDEX_6);
    assign prdata   = (cfg_idx <= gtb_pkg::REG_BIN_INDEX_6) ?
                      32'(bin_index_reg[cfg_idx]) : 32'd0;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_bin  = (bin_reg == LAST_BIN);

    assign trig_word = TRIG_TAB[bin_index_reg[bin_reg]*32 +: 32];

    always_comb
    begin
        mul_a = d1_reg[bin_reg];
        mul_b = {{8{cos_reg[15]}}, cos_reg, 1'b0};
        case (state_reg)
            ST_RE_MUL:
            begin
                mul_a = s0_reg;
                mul_b = 25'(cos_reg);
            end
            ST_RE_SUB:
            begin
                mul_a = s0_reg;
                mul_b = 25'(sin_reg);
            end
            ST_SQ_RE:
            begin
                mul_a = 40'($signed(re_reg[24:0]));
                mul_b = $signed(re_reg[24:0]);
            end
            ST_SQ_IM:
            begin
                mul_a = 40'($signed(im_reg[24:0]));
                mul_b = $signed(im_reg[24:0]);
            end
            default:
            begin
                mul_a = d1_reg[bin_reg];
                mul_b = {{8{cos_reg[15]}}, cos_reg, 1'b0};
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    assign s0_next = x_reg + $signed(prod_reg[54:15]) - d2_reg[bin_reg];
    assign re_next = $signed(prod_reg[55:15]) - 41'(d1_reg[bin_reg]);
    assign im_next = $signed(prod_reg[54:15]);
    assign ar_next = re_reg[gtb_pkg::DELAY_W] ? 41'(-re_reg) : 41'(re_reg);
    assign ai_next = im_next[gtb_pkg::DELAY_W-1] ? 40'(-im_next) : 40'(im_next);
    assign sq_sum_next = {1'b0, acc_reg} + {1'b0, prod_reg[47:0]};
    assign sq_start = (state_reg == ST_SQ_SUM);

    gtb_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_sum_next),
        .stat  (sq_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_reg       <= '0;
            count_reg     <= '0;
            blk_done_reg  <= 1'b0;
            blk_flag_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            cos_reg       <= '0;
            sin_reg       <= '0;
            prod_reg      <= '0;
            s0_reg        <= '0;
            re_reg        <= '0;
            im_reg        <= '0;
            sat_reg       <= 1'b0;
            acc_reg       <= '0;
            for (int i = 0; i < gtb_pkg::BANK; i++)
            begin
                d1_reg[i]        <= '0;
                d2_reg[i]        <= '0;
                held_reg[i]      <= '0;
                mag_out_reg[i]   <= '0;
                bin_index_reg[i] <= gtb_pkg::BIN_RESET[i];
            end
        end
        else
        begin
            if (cfg_wr)
                bin_index_reg[cfg_idx] <= pwdata[gtb_pkg::BIN_W-1:0];
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        x_reg        <= 40'(sample);
                        bin_reg      <= '0;
                        blk_done_reg <= (count_reg >= CNT_W'(BLOCK_LEN - 1));
                        count_reg    <= (count_reg >= CNT_W'(BLOCK_LEN - 1)) ?
                                        '0 : count_reg + CNT_W'(1);
                        state_reg    <= ST_COEF;
                    end
                end
                ST_COEF:
                begin
                    cos_reg   <= $signed(trig_word[31:16]);
                    sin_reg   <= $signed(trig_word[15:0]);
                    state_reg <= ST_FB_MUL;
                end
                ST_FB_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_FB_ADD;
                end
                ST_FB_ADD:
                begin
                    if (blk_done_reg)
                    begin
                        s0_reg    <= s0_next;
                        state_reg <= ST_RE_MUL;
                    end
                    else
                    begin
                        d2_reg[bin_reg] <= d1_reg[bin_reg];
                        d1_reg[bin_reg] <= s0_next;
                        bin_reg         <= bin_reg + 3'd1;
                        state_reg       <= last_bin ? ST_FINISH : ST_COEF;
                    end
                end
                ST_RE_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_RE_SUB;
                end
                ST_RE_SUB:
                begin
                    re_reg    <= re_next;
                    prod_reg  <= mul_p;
                    state_reg <= ST_IM;
                end
                ST_IM:
                begin
                    im_reg    <= im_next;
                    sat_reg   <= (ar_next > 41'(gtb_pkg::MAG_MAX)) ||
                                 (ai_next > 40'(gtb_pkg::MAG_MAX));
                    state_reg <= ST_SQ_RE;
                end
                ST_SQ_RE:
                begin
                    if (sat_reg)
                    begin
                        held_reg[bin_reg] <= gtb_pkg::MAG_MAX;
                        d1_reg[bin_reg]   <= '0;
                        d2_reg[bin_reg]   <= '0;
                        bin_reg           <= bin_reg + 3'd1;
                        state_reg         <= last_bin ? ST_FINISH : ST_COEF;
                    end
                    else
                    begin
                        prod_reg  <= mul_p;
                        state_reg <= ST_SQ_IM;
                    end
                end
                ST_SQ_IM:
                begin
                    acc_reg   <= prod_reg[47:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_SQ_SUM;
                end
                ST_SQ_SUM:
                begin
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (sq_stat.done)
                    begin
                        held_reg[bin_reg] <= (sq_stat.root > 25'(gtb_pkg::MAG_MAX)) ?
                                             gtb_pkg::MAG_MAX :
                                             sq_stat.root[gtb_pkg::MAG_W-1:0];
                        d1_reg[bin_reg]   <= '0;
                        d2_reg[bin_reg]   <= '0;
                        bin_reg           <= bin_reg + 3'd1;
                        state_reg         <= last_bin ? ST_FINISH : ST_COEF;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        for (int i = 0; i < gtb_pkg::BANK; i++)
                            mag_out_reg[i] <= held_reg[i];
                        blk_flag_reg  <= blk_done_reg;
                        out_valid_reg <= 1'b1;
                        bin_reg       <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign mag_bin0   = mag_out_reg[0];
    assign mag_bin1   = mag_out_reg[1];
    assign mag_bin2   = mag_out_reg[2];
    assign mag_bin3   = mag_out_reg[3];
    assign mag_bin4   = mag_out_reg[4];
    assign mag_bin5   = mag_out_reg[5];
    assign mag_bin6   = mag_out_reg[6];
    assign block_done = blk_flag_reg;

    a_root_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_stat.done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its wait state");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_COEF && bin_reg == '0)
        else $error("accepted sample did not start at the first bin");

    a_bin_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE && state_reg != ST_FINISH |-> bin_reg <= LAST_BIN)
        else $error("bin counter beyond last resonator");

    a_finish_beat: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH && out_free |=> out_valid && block_done == $past(blk_done_reg))
        else $error("finished sample did not produce its output beat");

endmodule

@@ sim/tb_top.sv @@
// Testbench for goertzel_tone_bank_core: directed table, random blocks, predictor check.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLOCK       = 256;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 400;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam logic [gtb_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic [gtb_pkg::BANK-1:0][gtb_pkg::MAG_W-1:0] mag;
        logic                                         done;
    } tone_beat_t;

    typedef struct {
        logic [15:0] value;
        bit          fixed;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [gtb_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [15:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [gtb_pkg::MAG_W-1:0] mag_bin0, mag_bin1, mag_bin2, mag_bin3;
    logic [gtb_pkg::MAG_W-1:0] mag_bin4, mag_bin5, mag_bin6;
    logic block_done;

    goertzel_tone_bank_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .mag_bin0(mag_bin0), .mag_bin1(mag_bin1), .mag_bin2(mag_bin2),
        .mag_bin3(mag_bin3), .mag_bin4(mag_bin4), .mag_bin5(mag_bin5),
        .mag_bin6(mag_bin6), .block_done(block_done)
    );

    logic [gtb_pkg::BIN_W-1:0] bin_k [gtb_pkg::BANK];
    int                        cos_q [gtb_pkg::BANK];
    int                        sin_q [gtb_pkg::BANK];
    longint                    z1 [gtb_pkg::BANK];
    longint                    z2 [gtb_pkg::BANK];
    int unsigned               blk_count;
    logic [gtb_pkg::MAG_W-1:0] held_mag [gtb_pkg::BANK];

    tone_beat_t  beat_q [$];
    int          err_count = 0;
    int          cycles = 0;
    int          burst_left = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic void tone_coef(input int k, output int c, output int s);
        longint unsigned ph, r, theta, t2, ts, tc, m;
        longint ss, cs;
        int cr, sr;
        int q;
        ph = (longint'(k % BLOCK) << 32) / BLOCK;
        q = int'((ph >> 30) & 3);
        r = ph & (Q30_ONE - 1);
        theta = (r * HALF_PI_Q30) >> 30;
        t2 = (theta * theta) >> 30;
        ts = theta;
        tc = Q30_ONE;
        ss = longint'(theta);
        cs = longint'(Q30_ONE);
        for (int n = 1; n <= 7; n++)
        begin
            ts = ((ts * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
            tc = ((tc * t2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1)
            begin
                ss -= longint'(ts);
                cs -= longint'(tc);
            end
            else
            begin
                ss += longint'(ts);
                cs += longint'(tc);
            end
        end
        if (cs < 0) cs = 0;
        if (ss < 0) ss = 0;
        m = (longint'(cs) + 16384) >> 15;
        cr = (m > 32767) ? 32767 : int'(m);
        m = (longint'(ss) + 16384) >> 15;
        sr = (m > 32767) ? 32767 : int'(m);
        case (q)
            0:
            begin
                c = cr;
                s = sr;
            end
            1:
            begin
                c = -sr;
                s = cr;
            end
            2:
            begin
                c = -cr;
                s = -sr;
            end
            default:
            begin
                c = sr;
                s = -cr;
            end
        endcase
    endfunction

    function automatic longint unsigned int_root(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [gtb_pkg::MAG_W-1:0] tone_magnitude(input longint re,
                                                                 input longint im);
        longint unsigned ar, ai, m;
        ar = (re < 0) ? -re : re;
        ai = (im < 0) ? -im : im;
        if (ar > gtb_pkg::MAG_MAX || ai > gtb_pkg::MAG_MAX) return gtb_pkg::MAG_MAX;
        m = int_root(ar * ar + ai * ai);
        return (m > gtb_pkg::MAG_MAX) ? gtb_pkg::MAG_MAX : m[gtb_pkg::MAG_W-1:0];
    endfunction

    function automatic void set_bin(input logic [gtb_pkg::IDX_W-1:0] idx,
                                    input logic [31:0] val);
        int c, s;
        if (idx < gtb_pkg::BANK)
        begin
            bin_k[idx] = val[gtb_pkg::BIN_W-1:0];
            tone_coef(int'(bin_k[idx]), c, s);
            cos_q[idx] = c;
            sin_q[idx] = s;
        end
    endfunction

    function automatic void clear_bank();
        for (int i = 0; i < gtb_pkg::BANK; i++)
        begin
            set_bin(i[gtb_pkg::IDX_W-1:0], 32'(gtb_pkg::BIN_RESET[i]));
            z1[i] = 0;
            z2[i] = 0;
            held_mag[i] = '0;
        end
        blk_count = 0;
    endfunction

    function automatic tone_beat_t tone_step(input logic signed [15:0] x);
        tone_beat_t b;
        logic signed [gtb_pkg::DELAY_W-1:0] w;
        longint s0, re, im;
        bit done;
        done = (blk_count >= BLOCK - 1);
        for (int i = 0; i < gtb_pkg::BANK; i++)
        begin
            w = (longint'(x) + ((longint'(2 * cos_q[i]) * z1[i]) >>> 15) - z2[i]);
            s0 = longint'(w);
            if (done)
            begin
                re = ((longint'(cos_q[i]) * s0) >>> 15) - z1[i];
                im = (longint'(sin_q[i]) * s0) >>> 15;
                held_mag[i] = tone_magnitude(re, im);
                z1[i] = 0;
                z2[i] = 0;
            end
            else
            begin
                z2[i] = z1[i];
                z1[i] = s0;
            end
            b.mag[i] = held_mag[i];
        end
        blk_count = done ? 0 : ((blk_count + 1) & 12'hFFF);
        b.done = done;
        return b;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
        err_count++;
    endtask

    always @(posedge clk)
    begin
        case ((cycles / 97) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= (cycles % 5 != 0);
        endcase
    end

    always @(negedge clk)
    begin
        tone_beat_t want;
        logic [gtb_pkg::MAG_W-1:0] got [gtb_pkg::BANK];
        if (rst_n && out_valid && out_ready)
        begin
            got = '{mag_bin0, mag_bin1, mag_bin2, mag_bin3, mag_bin4, mag_bin5, mag_bin6};
            if (beat_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                want = beat_q.pop_front();
                for (int i = 0; i < gtb_pkg::BANK; i++)
                    if (got[i] !== want.mag[i])
                        report_mismatch($sformatf("mag_bin%0d", i), got[i], want.mag[i]);
                if (block_done !== want.done)
                    report_mismatch("block_done", block_done, want.done);
            end
        end
    end

    task automatic write_reg(input logic [gtb_pkg::IDX_W-1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= gtb_pkg::ADDR_W'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        set_bin(idx, val);
        @(posedge clk);
    endtask

    task automatic push_sample(input logic [15:0] x, input bit fixed);
        tone_beat_t b;
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        b = tone_step(x);
        if (fixed)
        begin
            b.mag = '0;
            b.done = 1'b0;
        end
        beat_q.push_back(b);
        in_valid <= 1'b1;
        sample <= x;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (beat_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    stim_row_t opening [] = '{
        '{16'h7FFF, 1}, '{16'h8000, 1}, '{16'h0000, 1}, '{16'hFFFF, 1},
        '{16'h0001, 1}, '{16'h5555, 1}, '{16'hAAAA, 1}, '{16'h7FFF, 1},
        '{16'h7FFF, 1}, '{16'h8000, 1}, '{16'h8000, 1}, '{16'h0000, 1},
        '{16'h1234, 0}, '{16'hEDCB, 0}, '{16'h7FFF, 0}, '{16'h8001, 0}
    };

    initial
    begin
        clear_bank();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i]) push_sample(opening[i].value, opening[i].fixed);
        repeat (BLOCK - 16) push_sample(rand_sample(), 0);
        drain();

        for (int i = 0; i < gtb_pkg::BANK; i++) write_reg(i[gtb_pkg::IDX_W-1:0], 32'd0);
        write_reg(REG_UNUSED, 32'h7F);
        repeat (128) push_sample(16'h7FFF, 0);
        drain();

        for (int i = 0; i < gtb_pkg::BANK; i++) write_reg(i[gtb_pkg::IDX_W-1:0], 32'd127);
        repeat (64) push_sample(rand_sample(), 0);
        drain();

        for (int i = 0; i < gtb_pkg::BANK; i++) write_reg(i[gtb_pkg::IDX_W-1:0], $urandom);
        repeat (60) push_sample(rand_sample(), 0);
        drain();
        repeat (40) push_sample(rand_sample(), 0);
        drain();

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
